@@ hdl/lrmp_pkg.sv @@
// ----------------------------------------------------------------------------
// lrmp_pkg: shared types and constants
// Modulus, operand width and sequencer states for the matrix power block.
// ----------------------------------------------------------------------------
package lrmp_pkg;

  localparam int unsigned VW = 30;
  localparam logic [VW-1:0] MODULUS = 30'd998244353;

  typedef logic [VW-1:0] val_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_MUL,
    ST_WAIT,
    ST_SUM,
    ST_DONE
  } state_e;

endpackage

@@ hdl/linear_recurrence_matrix_power_mod_top.sv @@
// ----------------------------------------------------------------------------
// linear_recurrence_matrix_power_mod_top: n-th recurrence term mod 998244353
// 3x3 matrix square-and-multiply on one bit-serial modular multiplier.
// ----------------------------------------------------------------------------
// One beat in gives one beat out. Indices 0..2 go through the done state and
// return 1. Otherwise M^(n-2) is formed by square-and-multiply over
// the exponent bits (LSB first). Each exponent bit costs one squaring, and a
// set bit costs one acc*sq product ahead of it. Every matrix product is 27
// serial multiply-accumulates on the single modular multiplier. Each one is
// a start, 30 bit steps and a collect. A load state picks the next product.
// The column sum then takes 3 more multiplier passes. The multiplier loop
// sets the rate. Items are processed one at a time. The result waits in an
// output register, and the next index is taken only after the result has
// been delivered.
// ----------------------------------------------------------------------------
module linear_recurrence_matrix_power_mod_top
  import lrmp_pkg::*;
#(
  parameter int unsigned INDEX_BITS = 31
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [((INDEX_BITS+7)/8)*8-1:0] s_axis_tdata,  // [INDEX_BITS-1:0] term_index
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [31:0]           m_axis_tdata   // [29:0] term_value
);

  localparam int unsigned EW = INDEX_BITS;

  state_e state_q, state_d;

  logic [EW-1:0] exp_q;
  val_t acc_q [9];   // running power, row-major
  val_t sq_q  [9];   // running square
  val_t tmp_q [9];   // product being built
  logic          sq_pass_q;   // 0: acc*sq, 1: sq*sq
  logic [1:0]    i_q, j_q, k_q;
  val_t          sum_q;
  val_t          out_q;
  logic          out_v_q;
  val_t          sum_a;

  logic mm_start, mm_busy, mm_done;
  val_t mm_a, mm_b, mm_acc, mm_res;

  lrmp_modmul u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(mm_start),
    .a_i    (mm_a),
    .b_i    (mm_b),
    .acc_i  (mm_acc),
    .busy_o (mm_busy),
    .done_o (mm_done),
    .res_o  (mm_res)
  );

  // column sum reuses the multiplier: acc[i][2]*1 + running sum
  always_comb sum_a = acc_q[4'(i_q) * 4'd3 + 4'd2];

  logic [3:0] ik, kj, ij;
  always_comb begin
    ik = 4'(i_q) * 4'd3 + 4'(k_q);
    kj = 4'(k_q) * 4'd3 + 4'(j_q);
    ij = 4'(i_q) * 4'd3 + 4'(j_q);
    if (state_q == ST_SUM) begin
      mm_a   = sum_a;
      mm_b   = val_t'(1);
      mm_acc = sum_q;
    end else begin
      mm_a   = sq_pass_q ? sq_q[ik] : acc_q[ik];
      mm_b   = sq_q[kj];
      mm_acc = (k_q == 2'd0) ? '0 : tmp_q[ij];
    end
  end

  logic [EW-1:0] idx_in;
  assign idx_in = s_axis_tdata[EW-1:0];
  assign s_axis_tready = (state_q == ST_IDLE) && !out_v_q;
  logic in_fire;
  assign in_fire = s_axis_tvalid && s_axis_tready;
  logic last_mac;
  assign last_mac = (i_q == 2'd2) && (j_q == 2'd2) && (k_q == 2'd2);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: if (in_fire) state_d = (idx_in < EW'(3)) ? ST_DONE : ST_LOAD;
      ST_LOAD: state_d = (exp_q == '0) ? ST_SUM : ST_MUL;
      ST_MUL:  state_d = ST_WAIT;
      ST_WAIT: if (mm_done) state_d = last_mac ? ST_LOAD : ST_MUL;
      ST_SUM:  if (mm_done && i_q == 2'd2) state_d = ST_DONE;
      ST_DONE: state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    mm_start = 1'b0;
    case (state_q)
      ST_MUL:  mm_start = 1'b1;
      ST_SUM:  mm_start = !mm_busy && !mm_done;
      default: mm_start = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      out_v_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (m_axis_tvalid && m_axis_tready) out_v_q <= 1'b0;
      if (state_q == ST_DONE) out_v_q <= 1'b1;
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: if (in_fire) begin
        exp_q <= idx_in - EW'(2);
        sum_q <= val_t'(1);
        for (int n = 0; n < 9; n++) begin
          acc_q[n] <= (n % 4 == 0) ? val_t'(1) : '0;
        end
        sq_q[0] <= '0; sq_q[1] <= '0; sq_q[2] <= val_t'(1);
        sq_q[3] <= val_t'(1); sq_q[4] <= '0; sq_q[5] <= val_t'(1);
        sq_q[6] <= '0; sq_q[7] <= val_t'(1); sq_q[8] <= '0;
        sq_pass_q <= 1'b0;
      end
      ST_LOAD: begin
        // clear bit: go straight to the squaring
        i_q <= '0; j_q <= '0; k_q <= '0;
        sum_q <= '0;
        if (exp_q != '0 && !sq_pass_q && !exp_q[0]) sq_pass_q <= 1'b1;
      end
      ST_WAIT: if (mm_done) begin
        tmp_q[ij] <= mm_res;
        if (last_mac) begin
          i_q <= '0; j_q <= '0; k_q <= '0;
          if (sq_pass_q) begin
            for (int n = 0; n < 8; n++) sq_q[n] <= tmp_q[n];
            sq_q[8]   <= mm_res;
            exp_q     <= exp_q >> 1;
            sq_pass_q <= 1'b0;
          end else begin
            for (int n = 0; n < 8; n++) acc_q[n] <= tmp_q[n];
            acc_q[8]  <= mm_res;
            sq_pass_q <= 1'b1;
          end
        end else if (k_q != 2'd2) begin
          k_q <= k_q + 2'd1;
        end else begin
          k_q <= '0;
          if (j_q != 2'd2) j_q <= j_q + 2'd1;
          else begin
            j_q <= '0;
            i_q <= i_q + 2'd1;
          end
        end
      end
      ST_SUM: if (mm_done) begin
        sum_q <= mm_res;
        if (i_q != 2'd2) i_q <= i_q + 2'd1;
      end
      default: ;
    endcase
    if (state_q == ST_DONE) out_q <= sum_q;
  end

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = {2'b00, out_q};

  property p_hold_out;
    @(posedge clk_i) disable iff (!rst_ni)
      m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata);
  endproperty
  a_hold_out: assert property (p_hold_out) else $error("output not held");

  property p_no_take_busy;
    @(posedge clk_i) disable iff (!rst_ni) state_q != ST_IDLE |-> !s_axis_tready;
  endproperty
  a_no_take_busy: assert property (p_no_take_busy) else $error("ready while busy");

  property p_out_range;
    @(posedge clk_i) disable iff (!rst_ni) m_axis_tvalid |-> out_q < MODULUS;
  endproperty
  a_out_range: assert property (p_out_range) else $error("result not reduced");

  property p_start_idle;
    @(posedge clk_i) disable iff (!rst_ni) mm_start |-> !mm_busy && !mm_done;
  endproperty
  a_start_idle: assert property (p_start_idle) else $error("multiplier start while busy");

endmodule

@@ hdl/lrmp_modmul.sv @@
// ----------------------------------------------------------------------------
// lrmp_modmul: bit-serial modular multiply-accumulate
// Computes (acc + a*b) mod p, scanning b from its top bit, one bit a cycle.
// ----------------------------------------------------------------------------
module lrmp_modmul
  import lrmp_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start_i,
  input  val_t a_i,
  input  val_t b_i,
  input  val_t acc_i,
  output logic busy_o,
  output logic done_o,
  output val_t res_o
);

  localparam int unsigned CW = $clog2(VW + 1);

  val_t          a_q, b_q, r_q, acc_q;
  logic [CW-1:0] cnt_q;
  logic          busy_q, done_q;

  logic [VW+1:0] dbl, dsub, add, asub;
  val_t          r_dbl, r_add;

  always_comb begin
    dbl   = {2'b00, r_q} << 1;
    dsub  = dbl - {2'b00, MODULUS};
    r_dbl = dsub[VW+1] ? dbl[VW-1:0] : dsub[VW-1:0];
    add   = {2'b00, r_dbl} + (b_q[VW-1] ? {2'b00, a_q} : '0);
    asub  = add - {2'b00, MODULUS};
    r_add = asub[VW+1] ? add[VW-1:0] : asub[VW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i && !busy_q) begin
        busy_q <= 1'b1;
        cnt_q  <= CW'(VW);
      end else if (busy_q) begin
        if (cnt_q == CW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
        cnt_q <= cnt_q - CW'(1);
      end
    end
  end

  // accumulator added last through the same reduce step
  logic [VW+1:0] fin, fsub;
  always_comb begin
    fin  = {2'b00, r_q} + {2'b00, acc_q};
    fsub = fin - {2'b00, MODULUS};
  end

  always_ff @(posedge clk_i) begin
    if (start_i && !busy_q) begin
      a_q   <= a_i;
      b_q   <= b_i;
      acc_q <= acc_i;
      r_q   <= '0;
    end else if (busy_q) begin
      r_q <= r_add;
      b_q <= b_q << 1;
    end
  end

  assign busy_o = busy_q;
  assign done_o = done_q;
  assign res_o  = fsub[VW+1] ? fin[VW-1:0] : fsub[VW-1:0];

  property p_done_after_busy;
    @(posedge clk_i) disable iff (!rst_ni) done_q |-> $past(busy_q);
  endproperty
  a_done_after_busy: assert property (p_done_after_busy) else $error("done w/o busy");

  property p_no_both;
    @(posedge clk_i) disable iff (!rst_ni) !(done_q && busy_q);
  endproperty
  a_no_both: assert property (p_no_both) else $error("done while busy");

  property p_cnt_zero_idle;
    @(posedge clk_i) disable iff (!rst_ni) !busy_q |-> cnt_q == '0;
  endproperty
  a_cnt_zero_idle: assert property (p_cnt_zero_idle) else $error("count left over");

endmodule

@@ dv/linear_recurrence_matrix_power_mod_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// linear_recurrence_matrix_power_mod_checker: recurrence term scoreboard
// Watches both stream channels, works out each term from the accepted
// index and compares it with the returned beat in order.
// ----------------------------------------------------------------------------
module linear_recurrence_matrix_power_mod_checker
  import lrmp_pkg::*;
#(
  parameter int unsigned INDEX_BITS = 31
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  logic [31:0] in_data_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  logic [31:0] out_data_i,
  output int          pending_o,
  output int          fail_count_o
);

  typedef logic [9*VW-1:0] mat_t;  // row-major, entry (r,c) at (r*3+c)*VW

  val_t term_q[$];

  function automatic mat_t mat_mul(mat_t x, mat_t y);
    mat_t z;
    longint unsigned acc, a, b;
    z = '0;
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        acc = 0;
        for (int k = 0; k < 3; k++) begin
          a = x[(r*3+k)*VW +: VW];
          b = y[(k*3+c)*VW +: VW];
          acc = (acc + a * b) % longint'(MODULUS);
        end
        z[(r*3+c)*VW +: VW] = val_t'(acc);
      end
    end
    return z;
  endfunction

  function automatic val_t recurrence_term(logic [31:0] raw);
    longint unsigned n, sum;
    mat_t pw, sq;
    n = raw & ((64'd1 << INDEX_BITS) - 1);
    if (n < 3) return val_t'(1);
    n = n - 2;
    pw = '0;
    sq = '0;
    for (int d = 0; d < 3; d++) pw[(d*3+d)*VW +: VW] = val_t'(1);
    // base matrix {{0,0,1},{1,0,1},{0,1,0}}
    sq[(0*3+2)*VW +: VW] = val_t'(1);
    sq[(1*3+0)*VW +: VW] = val_t'(1);
    sq[(1*3+2)*VW +: VW] = val_t'(1);
    sq[(2*3+1)*VW +: VW] = val_t'(1);
    while (n != 0) begin
      if (n[0]) pw = mat_mul(pw, sq);
      sq = mat_mul(sq, sq);
      n = n >> 1;
    end
    sum = longint'(pw[2*VW +: VW]) + longint'(pw[5*VW +: VW]) + longint'(pw[8*VW +: VW]);
    return val_t'(sum % longint'(MODULUS));
  endfunction

  assign pending_o = term_q.size();

  always @(posedge clk_i or negedge rst_ni) begin
    val_t want;
    if (!rst_ni) begin
      fail_count_o <= 0;
    end else begin
      if (in_valid_i && in_ready_i) term_q.push_back(recurrence_term(in_data_i));
      if (out_valid_i && out_ready_i) begin
        if (term_q.size() == 0) begin
          if (fail_count_o < 10)
            $display("mismatch: unexpected beat term_value=%0d", out_data_i[VW-1:0]);
          fail_count_o <= fail_count_o + 1;
        end else begin
          want = term_q.pop_front();
          if (out_data_i[VW-1:0] !== want) begin
            if (fail_count_o < 10)
              $display("mismatch: term_value exp=%0d got=%0d", want, out_data_i[VW-1:0]);
            fail_count_o <= fail_count_o + 1;
          end
        end
      end
    end
  end

endmodule

@@ dv/linear_recurrence_matrix_power_mod_top_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// linear_recurrence_matrix_power_mod_top_tb: stimulus and verdict
// Drives term indices (directed corners, then mostly short random indices
// with a few full-width ones) under varying backpressure; the checker
// beside the block predicts and compares every term.
// ----------------------------------------------------------------------------
module linear_recurrence_matrix_power_mod_top_tb;
  import lrmp_pkg::*;

  localparam int unsigned INDEX_BITS = 31;
  localparam longint      CYCLE_LIMIT = 40_000_000;
  localparam int          N_RANDOM = 280;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata;   // [30:0] term_index, [31] pad
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [31:0] m_axis_tdata;   // [29:0] term_value

  int     pending_terms;
  int     fail_count;
  int     send_idle_pct;       // chance per beat of a sender gap
  int     recv_stall_pct;      // chance per cycle of receiver stall
  logic   hold_go;             // request for one long receiver hold-off
  int     hold_left;
  longint cycle_count;

  linear_recurrence_matrix_power_mod_top #(.INDEX_BITS(INDEX_BITS)) u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  linear_recurrence_matrix_power_mod_checker #(.INDEX_BITS(INDEX_BITS)) u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_i  (s_axis_tready),
    .in_data_i   (s_axis_tdata),
    .out_valid_i (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_i  (m_axis_tdata),
    .pending_o   (pending_terms),
    .fail_count_o(fail_count)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Receiver: random stalls, plus one long hold-off counted here so the
  // block stays full and the sender sees tready low. The hold-off outlasts
  // the slowest of the short indices sent during it.
  always @(posedge clk_i) begin
    if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      m_axis_tready <= 1'b0;
    end else if (hold_go) begin
      hold_go <= 1'b0;
      hold_left <= 20000;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Watchdog.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAIL linear_recurrence_matrix_power_mod_top");
      $finish;
    end
  end

  // One beat; valid stays high into the next beat unless a gap is drawn.
  task automatic send_index(logic [31:0] raw);
    if (s_axis_tvalid && $urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(6, 1)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= raw;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
  endtask

  task automatic go_idle();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
  endtask

  // Mostly short indices keep the run short; a few span the full width.
  function automatic logic [31:0] random_index();
    int pick;
    logic [31:0] v;
    pick = $urandom_range(99);
    v = $urandom;
    if (pick < 60)      v = v & 32'h3F;
    else if (pick < 92) v = v & 32'hFFF;
    else                v = v;          // full width, pad bit random too
    return v;
  endfunction

  initial begin
    logic [31:0] corners[$];
    s_axis_tvalid  = 1'b0;
    s_axis_tdata   = '0;
    m_axis_tready  = 1'b0;
    hold_go        = 1'b0;
    hold_left      = 0;
    cycle_count    = 0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    rst_ni         = 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // small indices, first recurrence terms, powers of two, full width,
    // and the pad bit above the index set
    corners = '{32'd0, 32'd1, 32'd2, 32'd3, 32'd4, 32'd5, 32'd6, 32'd7, 32'd10,
                32'd34, 32'd66, 32'd257, 32'h4000_0000, 32'h7FFF_FFFF,
                32'hFFFF_FFFF, 32'h8000_0002, 32'h8000_0009, 32'h5555_5555,
                32'h2AAA_AAAA};
    foreach (corners[i]) send_index(corners[i]);

    // long receiver hold-off while indices keep coming
    hold_go <= 1'b1;
    for (int i = 0; i < 6; i++) send_index(random_index() & 32'h1F);
    go_idle();
    wait (pending_terms == 0);

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 72; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 72; end
        default: begin send_idle_pct = 11; recv_stall_pct = 11; end
      endcase
      for (int i = 0; i < N_RANDOM / 4; i++) send_index(random_index());
      // sender pauses until the block has drained
      go_idle();
      wait (pending_terms == 0);
    end

    repeat (100) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("PASS linear_recurrence_matrix_power_mod_top");
    end else begin
      $display("FAIL linear_recurrence_matrix_power_mod_top");
    end
    $finish;
  end

endmodule
